[hdl/wbss_pkg.sv]
// Package for the wildcard byte signature scanner.
// Holds shared widths, parameter defaults and the register index codes.
// No dependencies.
`default_nettype none

package wbss_pkg;

   // parameter defaults
   localparam int MAX_PATTERN_DEF  = 16;
   localparam int ADDRESS_BITS_DEF = 48;

   // fixed field widths
   localparam int LEN_BITS       = 5;
   localparam int PATTERN_BITS   = 128;
   localparam int CARE_BITS      = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // register indexes of the csr write channel
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_CARE_MASK    = 3'd2,
      REG_PATTERN_LEN  = 3'd3,
      REG_RANGE_START  = 3'd4,
      REG_RANGE_END    = 3'd5
   } csr_reg_type;

endpackage

`default_nettype wire

[hdl/wbss_match.sv]
// Window compare and range check for the signature scanner.
// Purely combinational; uses wbss_pkg for widths.
`default_nettype none

module wbss_match #(
   parameter int MAX_PATTERN  = wbss_pkg::MAX_PATTERN_DEF,
   parameter int ADDRESS_BITS = wbss_pkg::ADDRESS_BITS_DEF
) (
   input  wire logic [7:0]                      win [MAX_PATTERN],
   input  wire logic [wbss_pkg::LEN_BITS-1:0]     fill,
   input  wire logic [wbss_pkg::PATTERN_BITS-1:0] pattern,
   input  wire logic [wbss_pkg::CARE_BITS-1:0]    care,
   input  wire logic [wbss_pkg::LEN_BITS-1:0]     len_raw,
   input  wire logic [ADDRESS_BITS-1:0]           addr,
   input  wire logic [ADDRESS_BITS-1:0]           range_start,
   input  wire logic [ADDRESS_BITS-1:0]           range_end,
   output logic                                   hit,
   output logic [ADDRESS_BITS-1:0]                start_addr
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [wbss_pkg::LEN_BITS-1:0] used_len;
   logic [ADDRESS_BITS-1:0]       len_a;
   logic                          bytes_ok;
   logic [IW-1:0]                 widx;

   // clamp length to 1..MAX_PATTERN
   always_comb begin
      priority if (len_raw == '0) begin
         used_len = wbss_pkg::LEN_BITS'(1);
      end else if (len_raw > wbss_pkg::LEN_BITS'(MAX_PATTERN)) begin
         used_len = wbss_pkg::LEN_BITS'(MAX_PATTERN);
      end else begin
         used_len = len_raw;
      end
   end

   // pattern byte j against window byte len-1-j; wildcards always pass
   always_comb begin
      bytes_ok = 1'b1;
      widx     = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if ((wbss_pkg::LEN_BITS'(j) < used_len) && care[j]) begin
            widx = IW'(used_len - wbss_pkg::LEN_BITS'(1) - wbss_pkg::LEN_BITS'(j));
            if (win[widx] != pattern[8*j +: 8]) begin
               bytes_ok = 1'b0;
            end
         end
      end
   end

   // start address wraps; range test decides
   assign len_a      = ADDRESS_BITS'(used_len);
   assign start_addr = addr - (len_a - ADDRESS_BITS'(1));
   assign hit        = (fill >= used_len) && bytes_ok && (range_end >= len_a)
                       && (start_addr >= range_start)
                       && (start_addr <= range_end - len_a);

endmodule

`default_nettype wire

[hdl/wbss_skid.sv]
// Output register plus one skid entry for the scanner result channel.
// Generic width; no package use.
`default_nettype none

module wbss_skid #(
   parameter int WIDTH = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output logic [WIDTH-1:0]      out_data,
   input  wire logic             out_ready
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;
   logic             take;

   assign take      = out_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // next state of the two entries
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

[hdl/wildcard_byte_signature_scan_core.sv]
// Wildcard byte signature scanner, top level.
// Depends on wbss_pkg, wbss_match and wbss_skid.
//
// Usage: while req_tready is high, memory bytes arrive one word per cycle
// on the req_ stream with their address; tuser carries the region flags.
// The block keeps a window of the newest bytes of the current region,
// compares it with the pattern (care mask bits of zero are wildcards) and,
// on a match whose start lies in [range_start, range_end - length], sends
// the start address on rsp_. Bytes that cause no match produce no rsp_ word.
// Registers are written over csr_ (always ready) while the block is idle;
// the user must keep to that, as the block itself does not enforce it.
// Throughput: one byte per cycle while req_tready is high. The window update
// and compare sit between the req_ handshake and the output register.
// Stall: an output register plus one skid entry hold results; the skid
// entry fills when a match arrives while the receiver stalls a full output
// register, and req_tready stays low for as long as the skid entry is full.
// Reset: window emptied, registers to their reset values, rsp_ empty.
`default_nettype none

module wildcard_byte_signature_scan_core #(
   parameter int MAX_PATTERN  = wbss_pkg::MAX_PATTERN_DEF,
   parameter int ADDRESS_BITS = wbss_pkg::ADDRESS_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   // input stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: data_byte[7:0], byte_address[ADDRESS_BITS+7:8], zero pad
   input  wire logic [((ADDRESS_BITS+15)/8)*8-1:0]   req_tdata,
   // tuser: region_first[0], region_scannable[1]
   input  wire logic [1:0]                           req_tuser,
   // result stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: match_address[ADDRESS_BITS-1:0], zero pad
   output logic [((ADDRESS_BITS+7)/8)*8-1:0]         rsp_tdata,
   // register writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [wbss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [wbss_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int OUT_W = ((ADDRESS_BITS + 7) / 8) * 8;
   localparam int LB    = wbss_pkg::LEN_BITS;

   // registers
   logic [63:0]                         pattern_low_ff, pattern_high_ff;
   logic [wbss_pkg::CARE_BITS-1:0]      care_mask_ff;
   logic [LB-1:0]                       pattern_len_ff;
   logic [ADDRESS_BITS-1:0]             range_start_ff, range_end_ff;

   // window state; index 0 is the newest byte
   logic [7:0]              window_ff [MAX_PATTERN];
   logic [7:0]              window_in [MAX_PATTERN];
   logic [LB-1:0]           fill_ff, fill_in, fill_base;

   logic [7:0]              data_byte;
   logic [ADDRESS_BITS-1:0] byte_address;
   logic                    region_first, region_scannable;
   logic                    accept, hit;
   logic [ADDRESS_BITS-1:0] start_addr, rsp_addr;

   assign data_byte        = req_tdata[7:0];
   assign byte_address     = req_tdata[8 +: ADDRESS_BITS];
   assign region_first     = req_tuser[0];
   assign region_scannable = req_tuser[1];
   assign accept           = req_tvalid && req_tready;
   assign csr_ready        = 1'b1;

   // register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= '1;
         pattern_len_ff  <= LB'(1);
         range_start_ff  <= '0;
         range_end_ff    <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wbss_pkg::REG_PATTERN_LOW:  pattern_low_ff  <= csr_data;
            wbss_pkg::REG_PATTERN_HIGH: pattern_high_ff <= csr_data;
            wbss_pkg::REG_CARE_MASK:    care_mask_ff    <= csr_data[wbss_pkg::CARE_BITS-1:0];
            wbss_pkg::REG_PATTERN_LEN:  pattern_len_ff  <= csr_data[LB-1:0];
            wbss_pkg::REG_RANGE_START:  range_start_ff  <= ADDRESS_BITS'(csr_data);
            wbss_pkg::REG_RANGE_END:    range_end_ff    <= ADDRESS_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   // window shift and fill count
   always_comb begin
      fill_base    = region_first ? '0 : fill_ff;
      window_in[0] = data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end
      fill_in = (fill_base < LB'(MAX_PATTERN)) ? fill_base + LB'(1) : fill_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= region_scannable ? fill_in : '0;
      end
      if (accept && region_scannable) begin
         window_ff <= window_in;
      end
   end

   wbss_match #(
      .MAX_PATTERN  (MAX_PATTERN),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_match (
      .win         (window_in),
      .fill        (fill_in),
      .pattern     ({pattern_high_ff, pattern_low_ff}),
      .care        (care_mask_ff),
      .len_raw     (pattern_len_ff),
      .addr        (byte_address),
      .range_start (range_start_ff),
      .range_end   (range_end_ff),
      .hit         (hit),
      .start_addr  (start_addr)
   );

   wbss_skid #(
      .WIDTH (ADDRESS_BITS)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && region_scannable && hit),
      .in_data   (start_addr),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_addr),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = OUT_W'(rsp_addr);

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LB'(MAX_PATTERN))
      else $error("window fill above depth");

   a_unscannable_clears: assert property (@(posedge clock) disable iff (reset)
      accept && !region_scannable |=> fill_ff == '0)
      else $error("unscannable byte did not empty window");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input blocked with no pending result");

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for the wildcard byte signature scanner core.
// Streams memory bytes through req_, checks match addresses on rsp_ against a
// local window predictor, and drives register writes on csr_. Needs wbss_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wbss_pkg::*;

   localparam int ADDR_W = ADDRESS_BITS_DEF;
   localparam int WIN_DEPTH = MAX_PATTERN_DEF;
   localparam int REQ_W = ((ADDR_W + 15) / 8) * 8;
   localparam int RSP_W = ((ADDR_W + 7) / 8) * 8;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam int CYCLE_LIMIT = 300000;
   localparam int STALL_HOLD = 200;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] SPARE_INDEX_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] SPARE_INDEX_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // tdata: data_byte, byte_address, zero pad
   logic [REQ_W-1:0] req_tdata = '0;
   // tuser: region_first, region_scannable
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // tdata: match_address
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   wildcard_byte_signature_scan_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow registers, reset values
   logic [63:0] pat_lo = '0;
   logic [63:0] pat_hi = '0;
   logic [CARE_BITS-1:0] care = '1;
   logic [LEN_BITS-1:0] len_reg = 5'd1;
   logic [ADDR_W-1:0] rng_lo = '0;
   logic [ADDR_W-1:0] rng_hi = '1;

   // shadow window, index 0 is the newest byte
   logic [7:0] win_bytes [WIN_DEPTH];
   int win_fill = 0;

   logic [ADDR_W-1:0] expected_matches [$];
   logic [ADDR_W-1:0] head_match;
   int mismatch_count = 0;
   int cycle_count = 0;

   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   int rsp_hold_cycles = 0;
   logic [ADDR_W-1:0] phase_base = '0;

   initial begin
      foreach (win_bytes[i]) win_bytes[i] = 8'h00;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int eff_len();
      if (len_reg == 0) return 1;
      if (len_reg > WIN_DEPTH) return WIN_DEPTH;
      return int'(len_reg);
   endfunction

   function automatic logic [7:0] pat_byte(input int j);
      logic [PATTERN_BITS-1:0] p;
      p = {pat_hi, pat_lo};
      return p[8*j +: 8];
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [63:0] v);
      case (idx)
         REG_PATTERN_LOW: pat_lo = v;
         REG_PATTERN_HIGH: pat_hi = v;
         REG_CARE_MASK: care = v[CARE_BITS-1:0];
         REG_PATTERN_LEN: len_reg = v[LEN_BITS-1:0];
         REG_RANGE_START: rng_lo = v[ADDR_W-1:0];
         REG_RANGE_END: rng_hi = v[ADDR_W-1:0];
         default: ;
      endcase
   endfunction

   // window update and masked compare for one accepted byte
   function automatic bit predict_match(input logic [7:0] d, input logic [ADDR_W-1:0] a,
                                        input bit first, input bit scan,
                                        output logic [ADDR_W-1:0] start_addr);
      int len;
      logic [ADDR_W-1:0] lend;
      start_addr = '0;
      if (!scan) begin
         win_fill = 0;
         return 1'b0;
      end
      if (first) win_fill = 0;
      for (int i = WIN_DEPTH - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
      win_bytes[0] = d;
      if (win_fill < WIN_DEPTH) win_fill++;
      len = eff_len();
      if (win_fill < len) return 1'b0;
      for (int j = 0; j < len; j++) begin
         if (care[j] && win_bytes[len-1-j] != pat_byte(j)) return 1'b0;
      end
      lend = ADDR_W'(len);
      if (rng_hi < lend) return 1'b0;
      start_addr = a - (lend - 1'b1);
      if (start_addr < rng_lo || start_addr > rng_hi - lend) return 1'b0;
      return 1'b1;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // offer one byte; valid stays high on return so back-to-back words work
   task automatic send_byte(input logic [7:0] d, input logic [ADDR_W-1:0] a,
                            input bit first, input bit scan);
      int gap;
      logic [ADDR_W-1:0] st;
      gap = tx_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({a, d});
      req_tuser <= {scan, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_match(d, a, first, scan, st)) expected_matches = {expected_matches, st};
   endtask

   // stop sending and wait for every outstanding match plus pipeline slack
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stall per word, or a long hold when asked
   initial begin
      int n;
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            n = rx_calm ? 0 : $urandom_range(0, 15);
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result check against the oldest expected match
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected match_address, expected none, actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            head_match = expected_matches.pop_front();
            if (rsp_tdata !== RSP_W'(head_match)) begin
               $display("%0t: match_address mismatch, expected %h, actual %h",
                        $time, head_match, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // reset values: zero pattern, one byte, full range
   task automatic test_reset_defaults();
      send_byte(8'h00, '0, 1'b1, 1'b1);
      send_byte(8'hFF, ADDR_MAX, 1'b0, 1'b1);
      send_byte(8'h00, ADDR_MAX, 1'b0, 1'b1);
      send_byte(8'h00, ADDR_MAX - 1'b1, 1'b0, 1'b1);
   endtask

   // wildcard middle byte, unscannable byte, region start, address gaps
   task automatic test_wildcards_and_regions();
      settle();
      write_reg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FF5A_3CA5);
      write_reg(REG_PATTERN_HIGH, 64'h0123_4567_89AB_CDEF);
      write_reg(REG_CARE_MASK, 64'hFFFF_FFFF_FFFF_FFFD);
      write_reg(REG_PATTERN_LEN, 64'h3);
      send_byte(8'hA5, 48'd100, 1'b1, 1'b1);
      send_byte(8'h77, 48'd101, 1'b0, 1'b1);
      send_byte(8'h5A, 48'd102, 1'b0, 1'b1);
      send_byte(8'hA5, 48'd103, 1'b0, 1'b1);
      send_byte(8'h00, 48'd104, 1'b0, 1'b0);
      send_byte(8'h5A, 48'd105, 1'b0, 1'b1);
      send_byte(8'hA5, 48'd200, 1'b1, 1'b1);
      send_byte(8'hA5, 48'd201, 1'b1, 1'b1);
      send_byte(8'h00, 48'd202, 1'b0, 1'b1);
      send_byte(8'h5A, 48'd203, 1'b0, 1'b1);
      send_byte(8'hA5, 48'd300, 1'b0, 1'b1);
      send_byte(8'hFF, 48'd310, 1'b0, 1'b1);
      send_byte(8'h5A, 48'd320, 1'b0, 1'b1);
   endtask

   // length zero and oversize length, spare indexes, range end below length
   task automatic test_length_and_range_limits();
      settle();
      write_reg(REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
      send_byte(8'hA5, 48'd400, 1'b0, 1'b1);
      settle();
      write_reg(SPARE_INDEX_A, rand64());
      write_reg(SPARE_INDEX_B, rand64());
      write_reg(REG_CARE_MASK, 64'h0);
      write_reg(REG_PATTERN_LEN, 64'hABCD_0000_0000_0031);
      for (int i = 1; i <= 8; i++) send_byte(8'($urandom), 48'(400 + i), 1'b0, 1'b1);
      settle();
      write_reg(REG_PATTERN_LEN, 64'h1);
      write_reg(REG_RANGE_END, 64'hFFFF_0000_0000_0001);
      send_byte(8'h3C, '0, 1'b1, 1'b1);
      settle();
      write_reg(REG_RANGE_END, 64'hFFFF_0000_0000_0000);
      send_byte(8'hC3, '0, 1'b1, 1'b1);
   endtask

   // every byte matches; receiver holds off so the core backs up req_
   task automatic test_stall_fill();
      logic [ADDR_W-1:0] a;
      settle();
      write_reg(REG_CARE_MASK, 64'h0);
      write_reg(REG_PATTERN_LEN, 64'h1);
      write_reg(REG_RANGE_START, 64'h0);
      write_reg(REG_RANGE_END, {16'h0, ADDR_MAX});
      a = ADDR_W'(rand64());
      tx_calm = 1'b1;
      rsp_hold_cycles = STALL_HOLD;
      for (int i = 0; i < 60; i++) begin
         send_byte(8'($urandom), a, i == 0, 1'b1);
         a = a + 1'b1;
      end
      settle();
      tx_calm = 1'b0;
   endtask

   // one register set per phase; extremes in the first phases
   task automatic randomize_config(input int phase);
      logic [63:0] r;
      logic [ADDR_W-1:0] lo, hi;
      int lraw;
      case ($urandom_range(0, 5))
         0: r = '0;
         1: r = '1;
         default: r = rand64();
      endcase
      write_reg(REG_PATTERN_LOW, r);
      case ($urandom_range(0, 5))
         0: r = '0;
         1: r = '1;
         default: r = rand64();
      endcase
      write_reg(REG_PATTERN_HIGH, r);
      r = rand64();
      case ($urandom_range(0, 4))
         0: r[15:0] = 16'h0000;
         1: r[15:0] = 16'hFFFF;
         default: ;
      endcase
      write_reg(REG_CARE_MASK, r);
      case (phase)
         0: lraw = WIN_DEPTH;
         1: lraw = 1;
         2: lraw = 0;
         3: lraw = 31;
         default: lraw = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 6)
                                                      : $urandom_range(0, 31);
      endcase
      r = rand64();
      r[4:0] = lraw[4:0];
      write_reg(REG_PATTERN_LEN, r);
      case ($urandom_range(0, 2))
         0: phase_base = ADDR_W'(rand64());
         1: phase_base = ADDR_W'($urandom_range(0, 50));
         default: phase_base = ADDR_MAX - $urandom_range(0, 200);
      endcase
      case ($urandom_range(0, 5))
         0, 1: begin
            lo = '0;
            hi = ADDR_MAX;
         end
         2: begin
            lo = phase_base + $urandom_range(0, 30);
            hi = lo + $urandom_range(0, 80);
         end
         3: begin
            lo = '0;
            hi = ADDR_W'($urandom_range(0, eff_len() - 1));
         end
         4: begin
            lo = ADDR_MAX - $urandom_range(0, 40);
            hi = ADDR_MAX;
         end
         default: begin
            lo = ADDR_W'(rand64());
            hi = ADDR_W'(rand64());
         end
      endcase
      r = rand64();
      r[ADDR_W-1:0] = lo;
      write_reg(REG_RANGE_START, r);
      r = rand64();
      r[ADDR_W-1:0] = hi;
      write_reg(REG_RANGE_END, r);
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? SPARE_INDEX_A : SPARE_INDEX_B, rand64());
   endtask

   // one region: mostly planted pattern copies and pattern-like bytes,
   // some unscannable noise, stray region starts and address jumps
   task automatic send_region(output int count);
      int rlen, k, plen;
      logic [ADDR_W-1:0] a;
      logic [7:0] d;
      bit scan, noisy;
      case ($urandom_range(0, 5))
         0: a = ADDR_W'(rand64());
         1: a = ADDR_W'($urandom_range(0, 20));
         2: a = ADDR_MAX - $urandom_range(0, 20);
         default: a = phase_base + $urandom_range(0, 40);
      endcase
      scan = ($urandom_range(0, 9) != 0);
      rlen = $urandom_range(1, 40);
      plen = eff_len();
      k = 0;
      while (k < rlen) begin
         if (scan && $urandom_range(0, 2) == 0) begin
            for (int j = 0; j < plen; j++) begin
               d = care[j] ? pat_byte(j) : 8'($urandom);
               send_byte(d, a, k == 0, 1'b1);
               a = a + 1'b1;
               k++;
            end
         end else begin
            noisy = ($urandom_range(0, 19) == 0);
            d = $urandom_range(0, 1) ? pat_byte($urandom_range(0, plen - 1)) : 8'($urandom);
            send_byte(d, a, k == 0 || $urandom_range(0, 29) == 0, scan && !noisy);
            if ($urandom_range(0, 29) == 0) a = a + $urandom_range(2, 1000);
            else a = a + 1'b1;
            k++;
         end
      end
      count = k;
   endtask

   task automatic test_random_scan();
      int sent, n;
      for (int phase = 0; phase < 10; phase++) begin
         settle();
         randomize_config(phase);
         tx_calm = ($urandom_range(0, 4) == 0);
         rx_calm = ($urandom_range(0, 4) == 0);
         sent = 0;
         while (sent < 115) begin
            send_region(n);
            sent += n;
         end
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_wildcards_and_regions();
      test_length_and_range_limits();
      test_stall_fill();
      test_random_scan();
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
